FILE: hw/rtl/jses_pkg.sv
// Shared types and constants for the JSON string and escape scanner.
package jses_pkg;

    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] MAX_LINE_LEN = 16'd65535;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [15:0] CH_QUOTE     = 16'h0022;
    localparam logic [15:0] CH_BACKSLASH = 16'h005C;
    localparam logic [15:0] CH_COLON     = 16'h003A;
    localparam logic [15:0] CH_SLASH     = 16'h002F;
    localparam logic [15:0] CH_B         = 16'h0062;
    localparam logic [15:0] CH_F         = 16'h0066;
    localparam logic [15:0] CH_N         = 16'h006E;
    localparam logic [15:0] CH_R         = 16'h0072;
    localparam logic [15:0] CH_T         = 16'h0074;
    localparam logic [15:0] CH_U         = 16'h0075;
    localparam logic [15:0] CH_DIGIT_0   = 16'h0030;
    localparam logic [15:0] CH_DIGIT_9   = 16'h0039;
    localparam logic [15:0] CH_LOWER_A   = 16'h0061;
    localparam logic [15:0] CH_LOWER_F   = 16'h0066;
    localparam logic [15:0] CH_UPPER_A   = 16'h0041;
    localparam logic [15:0] CH_UPPER_F   = 16'h0046;

    typedef enum logic [1:0] {
        KIND_STRING  = 2'd0,
        KIND_KEY     = 2'd1,
        KIND_GOOD_ESC = 2'd2,
        KIND_ESC_ERR = 2'd3
    } span_kind_t;

    typedef struct packed {
        span_kind_t       kind;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] stop;
    } span_t;

    typedef struct packed {
        logic  two_spans;
        span_t first;
        span_t second;
    } span_entry_t;

endpackage

FILE: hw/rtl/jses_if.sv
// Request channel interfaces for the scanner input and output.
interface jses_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_line;

    modport source (output valid, output code_unit, output end_of_line, input ready);
    modport sink (input valid, input code_unit, input end_of_line, output ready);
endinterface

interface jses_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  span_kind;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic        run_last;

    modport source (output valid, output span_kind, output span_start, output span_end,
                    output run_last, input ready);
    modport sink (input valid, input span_kind, input span_start, input span_end,
                  input run_last, output ready);
endinterface

FILE: hw/rtl/json_string_escape_scanner_top.sv
// Top level of the JSON string and escape scanner.
//
//   channel   role    payload
//   in_chan   sink    code_unit[15:0], end_of_line
//   out_chan  source  span_kind[1:0], span_start[15:0], span_end[15:0], run_last
//
// One character is accepted per cycle whenever the four-entry result queue has room.
// A character that yields spans pushes one entry, shown on out_chan once it heads the queue.
// Each span is its own output transfer, and run_last marks the last span of an entry.
// Reset clears the scanner and the queue, so the block is ready to accept input after reset.
// An output stall only stops input once the result queue is full.
module json_string_escape_scanner_top
    import jses_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    jses_in_if.sink    in_chan,
    jses_out_if.source out_chan
);

    logic        push;
    logic        pop;
    logic        empty;
    logic        full;
    span_entry_t push_entry;
    span_entry_t head;

    jses_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_chan (in_chan),
        .full    (full),
        .push    (push),
        .entry   (push_entry)
    );

    jses_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    jses_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .out_chan (out_chan)
    );

endmodule

FILE: hw/rtl/jses_front.sv
// Front end: accepts characters, runs the string scanner and builds result entries.
module jses_front
    import jses_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jses_in_if.sink     in_chan,
    input  logic        full,
    output logic        push,
    output span_entry_t entry
);

    typedef enum logic [2:0] {
        MODE_OUTSIDE = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_ESCAPE  = 3'd2,
        MODE_HEX0    = 3'd3,
        MODE_HEX1    = 3'd4,
        MODE_HEX2    = 3'd5,
        MODE_HEX3    = 3'd6
    } scan_mode_t;

    scan_mode_t       mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] open_start_reg, open_start_next;
    logic [POS_W-1:0] esc_start_reg, esc_start_next;
    logic [POS_W-1:0] prev_start_reg, prev_start_next;
    logic [POS_W-1:0] prev_end_reg, prev_end_next;
    logic             prev_valid_reg, prev_valid_next;

    logic             accept;
    logic             any_span;
    logic [15:0]      c;
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] nxt;
    logic             is_hex;
    logic             is_simple_esc;

    assign accept = in_chan.valid && in_chan.ready;
    assign in_chan.ready = !full;
    assign push = accept && any_span;
    assign c = in_chan.code_unit;
    assign cur = pos_reg;
    assign nxt = (cur >= MAX_LINE_LEN) ? MAX_LINE_LEN : cur + 1'b1;
    assign is_hex = (c inside {[CH_DIGIT_0:CH_DIGIT_9], [CH_LOWER_A:CH_LOWER_F],
                               [CH_UPPER_A:CH_UPPER_F]});
    assign is_simple_esc = (c inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F,
                                      CH_N, CH_R, CH_T});

    always_comb
    begin
        mode_next       = mode_reg;
        open_start_next = open_start_reg;
        esc_start_next  = esc_start_reg;
        prev_start_next = prev_start_reg;
        prev_end_next   = prev_end_reg;
        prev_valid_next = prev_valid_reg;
        pos_next        = nxt;
        any_span        = 1'b0;
        entry           = '0;

        case (mode_reg)
            MODE_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    any_span        = 1'b1;
                    entry.first     = '{KIND_STRING, open_start_reg, nxt};
                    prev_start_next = open_start_reg;
                    prev_end_next   = nxt;
                    prev_valid_next = 1'b1;
                    mode_next       = MODE_OUTSIDE;
                end
                else if (c == CH_BACKSLASH)
                begin
                    esc_start_next = cur;
                    mode_next      = MODE_ESCAPE;
                end
            end
            MODE_ESCAPE:
            begin
                if (is_simple_esc)
                begin
                    any_span    = 1'b1;
                    entry.first = '{KIND_GOOD_ESC, esc_start_reg, nxt};
                    mode_next   = MODE_STRING;
                end
                else if (c == CH_U)
                begin
                    if (in_chan.end_of_line)
                    begin
                        any_span    = 1'b1;
                        entry.first = '{KIND_ESC_ERR, esc_start_reg, nxt};
                    end
                    else
                    begin
                        mode_next = MODE_HEX0;
                    end
                end
                else
                begin
                    any_span    = 1'b1;
                    entry.first = '{KIND_ESC_ERR, esc_start_reg, nxt};
                    mode_next   = MODE_STRING;
                end
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3:
            begin
                if (is_hex)
                begin
                    if (in_chan.end_of_line)
                    begin
                        any_span    = 1'b1;
                        entry.first = '{KIND_ESC_ERR, esc_start_reg, nxt};
                    end
                    else if (mode_reg == MODE_HEX3)
                    begin
                        any_span    = 1'b1;
                        entry.first = '{KIND_GOOD_ESC, esc_start_reg, nxt};
                        mode_next   = MODE_STRING;
                    end
                    else
                    begin
                        mode_next = scan_mode_t'(3'(mode_reg) + 3'd1);
                    end
                end
                else
                begin
                    // The character that broke the escape is scanned again as string text.
                    any_span    = 1'b1;
                    entry.first = '{KIND_ESC_ERR, esc_start_reg, cur};
                    mode_next   = MODE_STRING;
                    if (c == CH_QUOTE)
                    begin
                        entry.two_spans = 1'b1;
                        entry.second    = '{KIND_STRING, open_start_reg, nxt};
                        prev_start_next = open_start_reg;
                        prev_end_next   = nxt;
                        prev_valid_next = 1'b1;
                        mode_next       = MODE_OUTSIDE;
                    end
                    else if (c == CH_BACKSLASH)
                    begin
                        esc_start_next = cur;
                        mode_next      = MODE_ESCAPE;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_OUTSIDE;
                if (c == CH_QUOTE)
                begin
                    open_start_next = cur;
                    mode_next       = MODE_STRING;
                end
                else if (c == CH_COLON && prev_valid_reg)
                begin
                    any_span    = 1'b1;
                    entry.first = '{KIND_KEY, prev_start_reg, prev_end_reg};
                end
            end
        endcase

        if (in_chan.end_of_line)
        begin
            mode_next       = MODE_OUTSIDE;
            pos_next        = '0;
            open_start_next = '0;
            esc_start_next  = '0;
            prev_start_next = '0;
            prev_end_next   = '0;
            prev_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_OUTSIDE;
            pos_reg        <= '0;
            open_start_reg <= '0;
            esc_start_reg  <= '0;
            prev_start_reg <= '0;
            prev_end_reg   <= '0;
            prev_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            open_start_reg <= open_start_next;
            esc_start_reg  <= esc_start_next;
            prev_start_reg <= prev_start_next;
            prev_end_reg   <= prev_end_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

endmodule

FILE: hw/rtl/jses_queue.sv
// Short queue of result entries between the scanner and the output stage.
module jses_queue
    import jses_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  span_entry_t push_entry,
    input  logic        pop,
    output span_entry_t head,
    output logic        empty,
    output logic        full
);

    span_entry_t          store_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/jses_back.sv
// Back end: hands out the one or two spans of each queued entry in order.
module jses_back
    import jses_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  span_entry_t head,
    input  logic        empty,
    output logic        pop,
    jses_out_if.source  out_chan
);

    logic  second_reg;
    logic  last;
    logic  fire;
    span_t cur_span;

    assign cur_span = second_reg ? head.second : head.first;
    assign last     = !head.two_spans || second_reg;
    assign fire     = out_chan.valid && out_chan.ready;
    assign pop      = fire && last;

    assign out_chan.valid      = !empty;
    assign out_chan.span_kind  = cur_span.kind;
    assign out_chan.span_start = cur_span.start;
    assign out_chan.span_end   = cur_span.stop;
    assign out_chan.run_last   = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else if (fire)
        begin
            second_reg <= !last;
        end
    end

endmodule
